/* rtl/yaw_rate_pid_gain_scheduled_defines.svh */
// Assertion macros for the yaw-rate PID term generator.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef YAW_RATE_PID_GAIN_SCHEDULED_DEFINES_SVH
`define YAW_RATE_PID_GAIN_SCHEDULED_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YRP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("yrp assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define YRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("yrp assertion failed: next-cycle implication");

`endif

/* rtl/yrp_pkg.sv */
// Shared types and constants for the yaw-rate PID term generator.
// No dependencies; imported by every module of the block.
package yrp_pkg;

    localparam int GAIN_W   = 16;
    localparam int SENSOR_W = 12;
    localparam int RATE_W   = 16;
    localparam int ERR_W    = RATE_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int SUM_W    = 32;
    localparam int TERM_W   = 24;
    localparam int FRAC_W   = 8;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int IN_W     = 76;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 72;

    localparam logic [SENSOR_W-1:0] THRESHOLD_RESET = '1;

    typedef enum logic [CFG_AW-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_GAIN_P_FAST   = 3'd3,
        REG_GAIN_I_FAST   = 3'd4,
        REG_GAIN_D_FAST   = 3'd5,
        REG_WALL_THR_LEFT = 3'd6,
        REG_WALL_THR_RIGHT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gain_set_t;

    typedef struct packed {
        gain_set_t           normal;
        gain_set_t           fast;
        logic [SENSOR_W-1:0] thr_left;
        logic [SENSOR_W-1:0] thr_right;
    } cfg_t;

    // Input item, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]              dead_end_phase;
        logic                    turning;
        logic [SENSOR_W-1:0]     sensor_right;
        logic [SENSOR_W-1:0]     sensor_left;
        logic                    run_mode_fast;
        logic signed [RATE_W-1:0] target_accel;
        logic signed [RATE_W-1:0] measured_rate;
        logic signed [RATE_W-1:0] target_rate;
    } in_item_t;

    // Operands handed from the error stage to the term multipliers.
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  integ;
        logic signed [DIFF_W-1:0] diff;
        gain_set_t                gains;
    } op_t;

    localparam logic [1:0] PHASE_NONE   = 2'd0;
    localparam logic [1:0] PHASE_ALIGN1 = 2'd1;
    localparam logic [1:0] PHASE_ALIGN2 = 2'd2;

endpackage

/* rtl/yrp_cfg.sv */
// Configuration register bank: scheduled gain sets and wall thresholds.
// Depends on yrp_pkg.
module yrp_cfg
    import yrp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_GAIN_P:         cfg_next.normal.kp = cfg_wdata;
                REG_GAIN_I:         cfg_next.normal.ki = cfg_wdata;
                REG_GAIN_D:         cfg_next.normal.kd = cfg_wdata;
                REG_GAIN_P_FAST:    cfg_next.fast.kp   = cfg_wdata;
                REG_GAIN_I_FAST:    cfg_next.fast.ki   = cfg_wdata;
                REG_GAIN_D_FAST:    cfg_next.fast.kd   = cfg_wdata;
                REG_WALL_THR_LEFT:  cfg_next.thr_left  = cfg_wdata[SENSOR_W-1:0];
                REG_WALL_THR_RIGHT: cfg_next.thr_right = cfg_wdata[SENSOR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal    <= '0;
            cfg_reg.fast      <= '0;
            cfg_reg.thr_left  <= THRESHOLD_RESET;
            cfg_reg.thr_right <= THRESHOLD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/yrp_err.sv */
// Error stage: rate error, saturating error integral with clear logic,
// error difference and gain selection. Holds the controller state. Uses yrp_pkg.
module yrp_err
    import yrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  in_item_t item,
    input  cfg_t     cfg,
    output op_t      op
);

    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [SUM_W-1:0] error_sum_next;
    logic signed [ERR_W-1:0] last_error_reg;
    op_t                     op_reg;
    op_t                     op_next;

    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    wall;
    logic                    clear;
    logic                    fast;

    always_comb begin
        err = ERR_W'(item.target_rate) - ERR_W'(item.measured_rate);
        sum_wide = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err);
        // The two top bits disagree only when the 32-bit sum overflowed.
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end

        wall  = (item.sensor_left > cfg.thr_left) || (item.sensor_right > cfg.thr_right);
        clear = (wall && !item.turning) || (item.dead_end_phase == PHASE_ALIGN1)
             || (item.dead_end_phase == PHASE_ALIGN2);
        error_sum_next = clear ? '0 : sum_sat;

        fast = item.run_mode_fast && (item.target_accel != '0);

        op_next.err   = err;
        op_next.integ = error_sum_next;
        op_next.diff  = DIFF_W'(err) - DIFF_W'(last_error_reg);
        op_next.gains = fast ? cfg.fast : cfg.normal;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end else if (adv) begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= err;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg <= op_next;
        end
    end

    assign op = op_reg;

endmodule

/* rtl/yrp_term.sv */
// One scaled term: signed value times unsigned Q8.8 gain, floor shift by 8,
// saturation to 24 bits. Uses yrp_pkg.
module yrp_term
    import yrp_pkg::*;
(
    input  logic signed [SUM_W-1:0]  value,
    input  logic        [GAIN_W-1:0] gain,
    output logic signed [TERM_W-1:0] term
);

    localparam int PROD_W = SUM_W + GAIN_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic                     in_range;

    always_comb begin
        prod = PROD_W'(value) * PROD_W'($signed({1'b0, gain}));
        // After the arithmetic shift the value fits in 24 bits only if all bits
        // from the 24-bit sign position up are copies of the sign.
        in_range = (prod[PROD_W-1:FRAC_W+TERM_W-1] == '0)
                || (prod[PROD_W-1:FRAC_W+TERM_W-1] == '1);
        if (in_range) begin
            term = prod[FRAC_W+TERM_W-1:FRAC_W];
        end else begin
            term = {prod[PROD_W-1], {(TERM_W-1){~prod[PROD_W-1]}}};
        end
    end

endmodule

/* rtl/yaw_rate_pid_gain_scheduled.sv */
// Yaw-rate PID term generator with gain scheduling: top level.
// Depends on yrp_pkg, yrp_cfg, yrp_err, yrp_term and the defines header.

// One transaction in gives one transaction out holding the P, I and D terms.
// The block takes a new input every cycle while the output is not stalled. An accepted
// input passes through the input register, operand register and result register and
// is then presented on m_tvalid.
// The error integral and previous error are updated as an item leaves the input
// register, so the sustained rate is one item per cycle while the output is not stalled.
// Backpressure on m_tready propagates combinationally to s_tready. Configuration
// writes take effect on the next cycle and should be made only while no transaction
// is in flight.
`include "yaw_rate_pid_gain_scheduled_defines.svh"

module yaw_rate_pid_gain_scheduled
    import yrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [CFG_DW-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // target_rate[15:0], measured_rate[31:16], target_accel[47:32],
    // run_mode_fast[48], sensor_left[60:49], sensor_right[72:61],
    // turning[73], dead_end_phase[75:74], zero fill [79:76]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // prop_term[23:0], integ_term[47:24], deriv_term[71:48]
    output logic [M_TDATA_W-1:0] m_tdata
);

    cfg_t     cfg;
    in_item_t in_reg;
    logic     in_valid_reg;
    logic     op_valid_reg;
    logic     out_valid_reg;
    op_t      op;

    logic out_ready;
    logic op_ready;
    logic in_adv;
    logic op_adv;

    logic signed [TERM_W-1:0] prop_term;
    logic signed [TERM_W-1:0] integ_term;
    logic signed [TERM_W-1:0] deriv_term;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    assign out_ready = !out_valid_reg || m_tready;
    assign op_ready  = !op_valid_reg || out_ready;
    assign op_adv    = op_valid_reg && out_ready;
    assign in_adv    = in_valid_reg && op_ready;
    assign s_tready  = !in_valid_reg || op_ready;

    yrp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (op_ready) begin
                op_valid_reg <= in_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= op_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= in_item_t'(s_tdata[IN_W-1:0]);
        end
    end

    yrp_err u_err (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (in_adv),
        .item    (in_reg),
        .cfg     (cfg),
        .op      (op)
    );

    yrp_term u_term_p (
        .value (SUM_W'(op.err)),
        .gain  (op.gains.kp),
        .term  (prop_term)
    );

    yrp_term u_term_i (
        .value (op.integ),
        .gain  (op.gains.ki),
        .term  (integ_term)
    );

    yrp_term u_term_d (
        .value (SUM_W'(op.diff)),
        .gain  (op.gains.kd),
        .term  (deriv_term)
    );

    always_ff @(posedge aclk) begin
        if (op_adv) begin
            m_tdata_reg <= {deriv_term, integ_term, prop_term};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // An empty result register means the whole pipeline can move.
    `YRP_ASSERT_NOW(a_ready_when_out_empty, !out_valid_reg, s_tready)
    // A stalled operand stage keeps its item and its operands.
    `YRP_ASSERT_NEXT(a_op_hold, op_valid_reg && !out_ready, op_valid_reg && $stable(op))
    // A stalled input register keeps its item.
    `YRP_ASSERT_NEXT(a_in_hold, in_valid_reg && !op_ready, in_valid_reg && $stable(in_reg))

endmodule
